FILE: design/assert_macros.svh
// Assertion macros used by the back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_ALWAYS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error("check failed");
`define CHK_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");
`else
`define CHK_ALWAYS(lbl, clk, rst, cond)
`define CHK_IMPLY(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: design/tag_pkg.sv
// Shared types and constants of the track association gate.
package tag_pkg;
  localparam int MAX_CANDIDATES_DEF = 32;
  localparam int COORD_BITS_DEF = 16;
  localparam int COORD_MAX = 24;
  localparam int MAX_RESULTS = 32;
  localparam int NUM_SMALL = 4;
  localparam int CFG_IDX_BITS = 8;
  localparam int CFG_DATA_BITS = 10;

  localparam logic [CFG_IDX_BITS-1:0] REG_ALPHA = 8'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_RATIO = 8'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAXE  = 8'd2;

  localparam logic [8:0] ALPHA_RST = 9'd128;
  localparam logic [9:0] RATIO_RST = 10'd307;
  localparam logic [2:0] MAXE_RST  = 3'd2;
  localparam logic [31:0] W_SAT = 32'hFFFF_FFFF;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef struct packed {
    logic                 req_type;
    logic                 first;
    logic [COORD_MAX-1:0] x;
    logic [COORD_MAX-1:0] y;
    logic [15:0]          size;
    logic [15:0]          src;
  } tag_item_t;

  typedef struct packed {
    logic [8:0] alpha_q8;
    logic [9:0] ratio_q8;
    logic [2:0] max_edges;
  } tag_cfg_t;

  typedef enum logic [3:0] {
    B_IDLE, B_EMPTY, B_RD, B_DIFF, B_SQX, B_SQY, B_ROOT, B_DIV1, B_DIV2,
    B_MUL, B_SUM, B_THR, B_ERD, B_ECHK, B_FLUSH
  } back_state_t;
endpackage

FILE: design/tag_front.sv
// Front end: accepts input transfers, cleans fields and queues them.
module tag_front #(
  parameter int COORD_BITS = tag_pkg::COORD_BITS_DEF
) (
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  req_type,
  input  logic                  first,
  input  logic [COORD_BITS-1:0] obj_x,
  input  logic [COORD_BITS-1:0] obj_y,
  input  logic [15:0]           obj_size,
  input  logic [15:0]           source_id,
  input  logic                  q_full,
  output logic                  push,
  output tag_pkg::tag_item_t    item
);
  import tag_pkg::*;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    item.req_type = req_type;
    // first only matters on a load
    item.first    = (req_type == REQ_LOAD) && first;
    item.x        = COORD_MAX'(obj_x);
    item.y        = COORD_MAX'(obj_y);
    // treat a zero size as one
    item.size     = (obj_size == 16'd0) ? 16'd1 : obj_size;
    item.src      = source_id;
  end
endmodule

FILE: design/tag_queue.sv
// Two-entry queue between the front end and the back end.
module tag_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  tag_pkg::tag_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               q_valid,
  output tag_pkg::tag_item_t head
);
  import tag_pkg::*;

  tag_item_t  slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule

FILE: design/tag_back.sv
// Back end: candidate table, weight sequencer, threshold and edge output.
`include "assert_macros.svh"
module tag_back #(
  parameter int MAX_CANDIDATES = tag_pkg::MAX_CANDIDATES_DEF,
  parameter int COORD_BITS     = tag_pkg::COORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  tag_pkg::tag_cfg_t  cfg,
  input  logic               q_valid,
  input  tag_pkg::tag_item_t q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        edge_source,
  output logic [4:0]         cand_index,
  output logic [31:0]        edge_weight,
  output logic               last,
  output logic               no_edge
);
  import tag_pkg::*;

  localparam int CB  = COORD_BITS;
  localparam int IW  = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
  localparam int CW  = $clog2(MAX_CANDIDATES + 1);
  localparam int F   = (63 - 2 * CB) / 2;
  localparam int RW  = CB + 1 + F;
  localparam int VW  = 2 * RW;
  localparam int NW  = RW + 16;
  localparam int SW  = $clog2(NW + 1);
  localparam int MW  = 2 * CB + 16;

  back_state_t state, state_next;

  logic [MW-1:0] cand_mem [MAX_CANDIDATES];
  logic [31:0]   wbuf [MAX_CANDIDATES];
  logic [MW-1:0] cand_q;
  logic [31:0]   wb_q;

  logic [CW-1:0] cnt;
  logic [CW-1:0] j;
  logic [2:0]    k;
  logic [CB-1:0] qx, qy, dx, dy;
  logic [15:0]   qs, qsrc, big, small_s;
  logic [2*CB:0] d2;
  logic [VW-1:0] v;
  logic [RW+1:0] sq_rem;
  logic [RW-1:0] root;
  logic [NW-1:0] num;
  logic [15:0]   drem, dvs;
  logic [SW-1:0] step;
  logic [NW-1:0] pos;
  logic [31:0]   sz;
  logic [NW+8:0] prod_a;
  logic [41:0]   prod_b;
  logic [31:0]   sw [NUM_SMALL];
  logic [31:0]   thr;
  logic [2:0]    ti;
  logic [5:0]    n;
  logic          pend_v;
  logic [IW-1:0] pend_idx;
  logic [31:0]   pend_w;

  logic          ld_out, ld_last, ld_noedge, ld_pend;
  logic          out_free, hit, j_end, wr_en, pass;
  logic [IW-1:0] wr_addr;
  logic [2:0]    me;
  logic [8:0]    a_sat;

  // candidate table and weight buffer, registered read at j
  assign wr_en   = (state == B_IDLE) && q_valid && (q_item.req_type == REQ_LOAD) &&
                   (q_item.first || (cnt < CW'(MAX_CANDIDATES)));
  assign wr_addr = q_item.first ? '0 : cnt[IW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      cand_mem[wr_addr] <= {q_item.x[CB-1:0], q_item.y[CB-1:0], q_item.size};
    end
    cand_q <= cand_mem[j[IW-1:0]];
  end

  // square root step: two bits of the radicand per cycle
  logic [RW+3:0] sq_t, sq_trial, sq_diff;
  logic          sq_ge;
  logic [RW+1:0] sq_rem_nx;
  logic [RW-1:0] root_nx;
  always_comb begin
    sq_t      = {sq_rem, v[VW-1:VW-2]};
    sq_trial  = {2'b00, root, 2'b01};
    sq_diff   = sq_t - sq_trial;
    sq_ge     = (sq_t >= sq_trial);
    sq_rem_nx = sq_ge ? sq_diff[RW+1:0] : sq_t[RW+1:0];
    root_nx   = {root[RW-2:0], sq_ge};
  end

  // restoring divider step: one quotient bit per cycle
  logic [16:0]   dv_t, dv_diff;
  logic          dv_ge;
  logic [15:0]   drem_nx;
  logic [NW-1:0] num_nx;
  always_comb begin
    dv_t    = {drem, num[NW-1]};
    dv_diff = dv_t - {1'b0, dvs};
    dv_ge   = (dv_t >= {1'b0, dvs});
    drem_nx = dv_ge ? dv_diff[15:0] : dv_t[15:0];
    num_nx  = {num[NW-2:0], dv_ge};
  end

  // weight sum with saturation
  logic [NW+9:0] w_sum;
  logic [31:0]   w_sat;
  always_comb begin
    w_sum = (NW+10)'(prod_a) + (NW+10)'(prod_b);
    w_sat = (|w_sum[NW+9:40]) ? W_SAT : w_sum[39:8];
  end

  // sorted insert into the k smallest weights
  logic [31:0] ins [NUM_SMALL];
  always_comb begin
    for (int i = 0; i < NUM_SMALL; i++) begin
      if (3'(i) >= k || sw[i] <= w_sat) begin
        ins[i] = sw[i];
      end else if (i == 0) begin
        ins[i] = w_sat;
      end else if (sw[(i == 0) ? 0 : i-1] <= w_sat) begin
        ins[i] = w_sat;
      end else begin
        ins[i] = sw[(i == 0) ? 0 : i-1];
      end
    end
  end

  logic [41:0] thr_lhs, thr_rhs;
  always_comb begin
    thr_lhs = 42'({sw[ti[1:0]], 8'd0});
    thr_rhs = thr * cfg.ratio_q8;
    pass    = (ti < k) && (thr_lhs < thr_rhs);
  end

  always_comb begin
    if (cfg.max_edges == 3'd0) me = 3'd1;
    else if (cfg.max_edges > 3'd4) me = 3'd4;
    else me = cfg.max_edges;
    a_sat = (cfg.alpha_q8 > 9'd256) ? 9'd256 : cfg.alpha_q8;
  end

  assign out_free = !out_valid || !out_stall;
  assign hit      = (wb_q <= thr) && (n < 6'(MAX_RESULTS));
  assign j_end    = ((j + CW'(1)) == cnt);

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    ld_out     = 1'b0;
    ld_last    = 1'b0;
    ld_noedge  = 1'b0;
    ld_pend    = 1'b0;
    case (state)
      B_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_item.req_type == REQ_QUERY) begin
            state_next = (cnt == '0) ? B_EMPTY : B_RD;
          end
        end
      end
      B_EMPTY: begin
        if (out_free) begin
          ld_out     = 1'b1;
          ld_last    = 1'b1;
          ld_noedge  = 1'b1;
          state_next = B_IDLE;
        end
      end
      B_RD:   state_next = B_DIFF;
      B_DIFF: state_next = B_SQX;
      B_SQX:  state_next = B_SQY;
      B_SQY:  state_next = B_ROOT;
      B_ROOT: if (step == SW'(RW - 1)) state_next = B_DIV1;
      B_DIV1: if (step == SW'(NW - 1)) state_next = B_DIV2;
      B_DIV2: if (step == SW'(NW - 1)) state_next = B_MUL;
      B_MUL:  state_next = B_SUM;
      B_SUM:  state_next = j_end ? B_THR : B_RD;
      B_THR:  if (!pass) state_next = B_ERD;
      B_ERD:  state_next = B_ECHK;
      B_ECHK: begin
        if (!(hit && pend_v && !out_free)) begin
          if (hit && pend_v) begin
            ld_out  = 1'b1;
            ld_pend = 1'b1;
          end
          state_next = j_end ? B_FLUSH : B_ERD;
        end
      end
      B_FLUSH: begin
        if (out_free) begin
          ld_out     = 1'b1;
          ld_pend    = 1'b1;
          ld_last    = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (wr_en) begin
        cnt <= q_item.first ? CW'(1) : cnt + CW'(1);
      end else if (state == B_IDLE && q_valid && q_item.first) begin
        cnt <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_SUM) begin
      wbuf[j[IW-1:0]] <= w_sat;
    end
    wb_q <= wbuf[j[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        qx   <= q_item.x[CB-1:0];
        qy   <= q_item.y[CB-1:0];
        qs   <= q_item.size;
        qsrc <= q_item.src;
        j    <= '0;
        k    <= (7'(cnt) < 7'(me)) ? 3'(cnt) : me;
        for (int i = 0; i < NUM_SMALL; i++) sw[i] <= W_SAT;
      end
      B_DIFF: begin
        dx <= (qx > cand_q[MW-1:CB+16]) ? qx - cand_q[MW-1:CB+16]
                                        : cand_q[MW-1:CB+16] - qx;
        dy <= (qy > cand_q[CB+15:16]) ? qy - cand_q[CB+15:16]
                                      : cand_q[CB+15:16] - qy;
        big     <= (qs > cand_q[15:0]) ? qs : cand_q[15:0];
        small_s <= (qs > cand_q[15:0]) ? cand_q[15:0] : qs;
      end
      B_SQX: d2 <= (2*CB+1)'(dx * dx);
      B_SQY: begin
        v      <= VW'(d2 + (2*CB+1)'(dy * dy)) << (2 * F);
        sq_rem <= '0;
        root   <= '0;
        step   <= '0;
      end
      B_ROOT: begin
        v      <= v << 2;
        sq_rem <= sq_rem_nx;
        root   <= root_nx;
        step   <= step + SW'(1);
        if (step == SW'(RW - 1)) begin
          num  <= {root_nx, 16'd0};
          drem <= '0;
          dvs  <= qs;
          step <= '0;
        end
      end
      B_DIV1: begin
        num  <= num_nx;
        drem <= drem_nx;
        step <= step + SW'(1);
        if (step == SW'(NW - 1)) begin
          pos  <= num_nx >> F;
          num  <= NW'({big - small_s, 16'd0});
          drem <= '0;
          dvs  <= small_s;
          step <= '0;
        end
      end
      B_DIV2: begin
        num  <= num_nx;
        drem <= drem_nx;
        step <= step + SW'(1);
        if (step == SW'(NW - 1)) sz <= num_nx[31:0];
      end
      B_MUL: begin
        prod_a <= a_sat * pos;
        prod_b <= (9'd256 - a_sat) * sz;
      end
      B_SUM: begin
        for (int i = 0; i < NUM_SMALL; i++) sw[i] <= ins[i];
        j   <= j + CW'(1);
        thr <= ins[0];
        ti  <= 3'd1;
      end
      B_THR: begin
        if (pass) begin
          thr <= sw[ti[1:0]];
          ti  <= ti + 3'd1;
        end else begin
          j      <= '0;
          n      <= '0;
          pend_v <= 1'b0;
        end
      end
      B_ECHK: begin
        if (!(hit && pend_v && !out_free)) begin
          if (hit) begin
            pend_v   <= 1'b1;
            pend_idx <= j[IW-1:0];
            pend_w   <= wb_q;
            n        <= n + 6'd1;
          end
          j <= j + CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // result register, holds while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ld_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      edge_source <= qsrc;
      cand_index  <= ld_pend ? 5'(pend_idx) : 5'd0;
      edge_weight <= ld_pend ? pend_w : 32'd0;
      last        <= ld_last;
      no_edge     <= ld_noedge;
    end
  end

  `CHK_ALWAYS(a_cnt_bound, clk, rst, cnt <= CW'(MAX_CANDIDATES))
  `CHK_IMPLY(a_ld_free, clk, rst, ld_out, out_free)
  `CHK_IMPLY(a_flush_pend, clk, rst, state == B_FLUSH, pend_v)
  `CHK_IMPLY(a_n_bound, clk, rst, state == B_ECHK, n <= 6'(MAX_RESULTS))
endmodule

FILE: design/track_association_gate_core.sv
// Top level of the track association gate: config registers and block wiring.
// Usage:
//   Input channel (in_valid / in_stall): a transfer with req_type 0 loads one
//   next-frame candidate (first empties the table first; loads past capacity
//   are dropped). req_type 1 queries the table with a current-frame object.
//   Output channel (out_valid / out_stall): a query yields one edge per gated
//   candidate, in table order, last set on the final one; an empty table
//   yields a single no_edge result.
//   Config channel (cfg_valid / cfg_ready): write alpha_q8, ratio_q8, max_edges
//   by index while the block is idle; cfg_ready is always high.
// Sequence:
//   A load is taken while the back end is idle. A query runs, for each
//   stored candidate: setup (read, difference, two squares), RW=32 square
//   root steps, two 48-step restoring divisions through one shared divider,
//   multiply, sum; then a threshold search over the smallest weights, then
//   the emit scan over the table, which waits on any output stall.
//   A two-entry queue lets the front end take items while a query runs.
// Reset clears the candidate count, queue and output valid; config returns to
// its defaults. A stall on the output holds the result register and the emit
// scan waits; the queue fills and then in_stall rises.
module track_association_gate_core #(
  parameter int MAX_CANDIDATES = tag_pkg::MAX_CANDIDATES_DEF,
  parameter int COORD_BITS     = tag_pkg::COORD_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               req_type,
  input  logic                               first,
  input  logic [COORD_BITS-1:0]              obj_x,
  input  logic [COORD_BITS-1:0]              obj_y,
  input  logic [15:0]                        obj_size,
  input  logic [15:0]                        source_id,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [15:0]                        edge_source,
  output logic [4:0]                         cand_index,
  output logic [31:0]                        edge_weight,
  output logic                               last,
  output logic                               no_edge,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tag_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [tag_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import tag_pkg::*;

  tag_cfg_t  cfg;
  tag_item_t f_item, q_head;
  logic      f_push, q_full, q_valid, q_pop;

  // config port never backpressures
  assign cfg_ready = 1'b1;

  // hold config registers; writes to unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.alpha_q8  <= ALPHA_RST;
      cfg.ratio_q8  <= RATIO_RST;
      cfg.max_edges <= MAXE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ALPHA: cfg.alpha_q8  <= cfg_data[8:0];
        REG_RATIO: cfg.ratio_q8  <= cfg_data[9:0];
        REG_MAXE:  cfg.max_edges <= cfg_data[2:0];
        default: begin
        end
      endcase
    end
  end

  // front end: accept and clean each transfer
  tag_front #(.COORD_BITS(COORD_BITS)) u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (req_type),
    .first     (first),
    .obj_x     (obj_x),
    .obj_y     (obj_y),
    .obj_size  (obj_size),
    .source_id (source_id),
    .q_full    (q_full),
    .push      (f_push),
    .item      (f_item)
  );

  // decouple front and back
  tag_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_push),
    .push_item (f_item),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .head      (q_head)
  );

  // back end: table, weights, threshold, edges
  tag_back #(.MAX_CANDIDATES(MAX_CANDIDATES), .COORD_BITS(COORD_BITS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_valid     (q_valid),
    .q_item      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .edge_source (edge_source),
    .cand_index  (cand_index),
    .edge_weight (edge_weight),
    .last        (last),
    .no_edge     (no_edge)
  );
endmodule

FILE: bench/tb_top.sv
// Self-checking bench for the track association gate core.
`timescale 1ns / 100ps

module tb_top;
  import tag_pkg::*;

  localparam int CAND_DEPTH = 32;
  localparam int SQRT_SHIFT = 15;
  localparam int IDLE_LIMIT = 20000;

  typedef struct {
    logic        req;
    logic        first;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] size;
    logic [15:0] src;
  } obj_req_t;

  typedef struct {
    logic [15:0] src;
    logic [4:0]  idx;
    logic [31:0] weight;
    logic        last;
    logic        no_edge;
  } edge_rec_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic req_type;
  logic first;
  logic [15:0] obj_x;
  logic [15:0] obj_y;
  logic [15:0] obj_size;
  logic [15:0] source_id;
  logic out_valid;
  logic out_stall;
  logic [15:0] edge_source;
  logic [4:0] cand_index;
  logic [31:0] edge_weight;
  logic last;
  logic no_edge;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  track_association_gate_core u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .first(first),
    .obj_x(obj_x), .obj_y(obj_y), .obj_size(obj_size), .source_id(source_id),
    .out_valid(out_valid), .out_stall(out_stall),
    .edge_source(edge_source), .cand_index(cand_index), .edge_weight(edge_weight),
    .last(last), .no_edge(no_edge),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow copy of the block's registers and candidate table.
  logic [8:0]  alpha_m;
  logic [9:0]  ratio_m;
  logic [2:0]  maxe_m;
  logic [15:0] tbl_x [CAND_DEPTH];
  logic [15:0] tbl_y [CAND_DEPTH];
  logic [15:0] tbl_s [CAND_DEPTH];
  int          tbl_count;

  obj_req_t  pend_items[$];
  edge_rec_t edges_due[$];

  int  errors;
  int  n_in, n_out, n_cfg, n_queries;
  bit  quiet;
  int  hold_asks, hold_taken;

  // Integer square root, floor.
  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Association cost between a query object (a) and a stored candidate (b).
  function automatic logic [31:0] assoc_cost(input logic [15:0] ax, ay, as_in,
                                             input logic [15:0] bx, by, bs);
    logic [63:0] dx, dy, d2, root, pos, big, sml, szt, a, w, as64, bs64;
    as64 = as_in;
    bs64 = bs;
    dx = (ax > bx) ? ax - bx : bx - ax;
    dy = (ay > by) ? ay - by : by - ay;
    d2 = dx * dx + dy * dy;
    root = isqrt64(d2 << (2 * SQRT_SHIFT));
    pos = ((root << 16) / as64) >> SQRT_SHIFT;
    big = (as64 > bs64) ? as64 : bs64;
    sml = (as64 > bs64) ? bs64 : as64;
    szt = ((big - sml) << 16) / sml;
    a = (alpha_m > 9'd256) ? 64'd256 : 64'(alpha_m);
    w = (a * pos + (64'd256 - a) * szt) >> 8;
    return (w > 64'hFFFF_FFFF) ? W_SAT : w[31:0];
  endfunction

  // Apply one accepted transfer to the shadow table; queue the edges it yields.
  function automatic void gate_predict(input obj_req_t it);
    logic [15:0] s;
    logic [63:0] wts [CAND_DEPTH];
    logic [63:0] best [NUM_SMALL];
    logic [63:0] thr;
    int me, k, filled, p, n, lastpos;
    edge_rec_t e;
    s = (it.size == 0) ? 16'd1 : it.size;
    if (it.req == REQ_LOAD) begin
      if (it.first) tbl_count = 0;
      if (tbl_count < CAND_DEPTH) begin
        tbl_x[tbl_count] = it.x;
        tbl_y[tbl_count] = it.y;
        tbl_s[tbl_count] = s;
        tbl_count++;
      end
      return;
    end
    n_queries++;
    if (tbl_count == 0) begin
      e = '{src: it.src, idx: 5'd0, weight: 32'd0, last: 1'b1, no_edge: 1'b1};
      edges_due.insert(edges_due.size(), e);
      return;
    end
    me = (maxe_m < 1) ? 1 : (maxe_m > NUM_SMALL) ? NUM_SMALL : int'(maxe_m);
    k = (tbl_count < me) ? tbl_count : me;
    for (int i = 0; i < NUM_SMALL; i++) best[i] = 64'(W_SAT);
    for (int j = 0; j < tbl_count; j++) begin
      wts[j] = assoc_cost(it.x, it.y, s, tbl_x[j], tbl_y[j], tbl_s[j]);
      filled = (j < k) ? j : k;
      p = filled;
      while (p > 0 && best[p-1] > wts[j]) begin
        if (p < k) best[p] = best[p-1];
        p--;
      end
      if (p < k) best[p] = wts[j];
    end
    thr = best[0];
    for (int i = 1; i < k; i++) begin
      if (best[i] * 256 < thr * ratio_m) thr = best[i];
      else break;
    end
    n = 0;
    lastpos = edges_due.size();
    for (int j = 0; j < tbl_count && n < MAX_RESULTS; j++) begin
      if (wts[j] <= thr) begin
        e = '{src: it.src, idx: 5'(j), weight: wts[j][31:0], last: 1'b0, no_edge: 1'b0};
        edges_due.insert(edges_due.size(), e);
        n++;
      end
    end
    // Mark the final edge of this query.
    edges_due[lastpos + n - 1].last = 1'b1;
  endfunction

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Sender: pop pending items, insert random idle bursts between transfers.
  int send_gap;
  always @(posedge clk) begin
    obj_req_t it;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        it = '{req: req_type, first: first, x: obj_x, y: obj_y,
               size: obj_size, src: source_id};
        gate_predict(it);
        n_in++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pend_items.size() > 0) begin
          it = pend_items.pop_front();
          in_valid <= 1'b1;
          req_type <= it.req;
          first <= it.first;
          obj_x <= it.x;
          obj_y <= it.y;
          obj_size <= it.size;
          source_id <= it.src;
          if (!quiet && $urandom_range(0, 4) == 0) send_gap <= $urandom_range(1, 7);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stall bursts plus an occasional long hold-off.
  int stall_left;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
      hold_taken <= 0;
    end else if (hold_taken != hold_asks) begin
      hold_taken <= hold_taken + 1;
      stall_left <= 3000;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 6);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Check every result transfer against the oldest predicted edge.
  always @(posedge clk) begin
    edge_rec_t e;
    if (!rst && out_valid && !out_stall) begin
      n_out++;
      if (edges_due.size() == 0) begin
        $error("unexpected result: source %0d index %0d", edge_source, cand_index);
        errors++;
      end else begin
        e = edges_due.pop_front();
        if (edge_source !== e.src) begin
          $error("edge_source exp %0d got %0d", e.src, edge_source); errors++;
        end
        if (cand_index !== e.idx) begin
          $error("cand_index exp %0d got %0d", e.idx, cand_index); errors++;
        end
        if (edge_weight !== e.weight) begin
          $error("edge_weight exp %h got %h", e.weight, edge_weight); errors++;
        end
        if (last !== e.last) begin
          $error("last exp %0d got %0d", e.last, last); errors++;
        end
        if (no_edge !== e.no_edge) begin
          $error("no_edge exp %0d got %0d", e.no_edge, no_edge); errors++;
        end
      end
    end
  end

  // Watchdog: count cycles with no transfer on any channel.
  int idle_cycles;
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("FAIL track_association_gate_core");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_obj(input logic req, input logic fst, input logic [15:0] x, y, s, src);
    obj_req_t it;
    it = '{req: req, first: fst, x: x, y: y, size: s, src: src};
    pend_items.insert(pend_items.size(), it);
  endtask

  // Hold until every transfer is out and every edge has come, then let loads drain.
  task automatic settle();
    while (pend_items.size() != 0 || in_valid || edges_due.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [9:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    n_cfg++;
    case (idx)
      REG_ALPHA: alpha_m = val[8:0];
      REG_RATIO: ratio_m = val;
      REG_MAXE:  maxe_m = val[2:0];
      default: ;
    endcase
  endtask

  function automatic logic [15:0] near(input logic [15:0] c);
    if ($urandom_range(0, 7) == 0) return 16'($urandom);
    return c + 16'($urandom_range(0, 300));
  endfunction

  function automatic logic [15:0] pick_size();
    case ($urandom_range(0, 9))
      0: return 16'd1;
      1: return 16'hFFFF;
      2: return 16'($urandom);
      default: return 16'($urandom_range(4, 160));
    endcase
  endfunction

  // One frame: fresh table of candidates, then a few queries against it.
  task automatic rand_frame(inout int budget);
    logic [15:0] cx, cy;
    int n;
    cx = 16'($urandom);
    cy = 16'($urandom);
    n = ($urandom_range(0, 11) == 0) ? $urandom_range(28, 34) : $urandom_range(1, 6);
    for (int i = 0; i < n; i++)
      push_obj(REQ_LOAD, i == 0 || $urandom_range(0, 19) == 0, near(cx), near(cy),
               pick_size(), 16'($urandom));
    for (int q = $urandom_range(1, 3); q > 0; q--)
      push_obj(REQ_QUERY, 1'($urandom), near(cx), near(cy), pick_size(), 16'($urandom));
    budget -= n + 2;
  endtask

  initial begin
    int budget;
    errors = 0; n_in = 0; n_out = 0; n_cfg = 0; n_queries = 0;
    quiet = 0; hold_asks = 0;
    alpha_m = ALPHA_RST; ratio_m = RATIO_RST; maxe_m = MAXE_RST;
    tbl_count = 0;
    in_valid = 1'b0; req_type = 1'b0; first = 1'b0;
    obj_x = '0; obj_y = '0; obj_size = 16'd1; source_id = '0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    out_stall = 1'b0;
    rst = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty table, extremes, identical object, zero size, ignored first.
    push_obj(REQ_QUERY, 1'b0, 16'd0, 16'd0, 16'd1, 16'hFFFF);
    push_obj(REQ_LOAD, 1'b1, 16'd0, 16'd0, 16'd1, 16'd0);
    push_obj(REQ_LOAD, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_obj(REQ_LOAD, 1'b0, 16'd100, 16'd100, 16'd20, 16'd0);
    push_obj(REQ_LOAD, 1'b0, 16'd105, 16'd98, 16'd22, 16'd0);
    push_obj(REQ_QUERY, 1'b1, 16'd100, 16'd100, 16'd20, 16'd7);
    push_obj(REQ_QUERY, 1'b0, 16'hFFFF, 16'd0, 16'd1, 16'd0);
    push_obj(REQ_QUERY, 1'b0, 16'd0, 16'hFFFF, 16'd0, 16'h5555);
    push_obj(REQ_QUERY, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hAAAA);
    settle();

    // Overfill the table: loads past capacity are dropped.
    for (int i = 0; i < 35; i++)
      push_obj(REQ_LOAD, i == 0, 16'(500 + i * 3), 16'(700 - i), 16'(30 + i), 16'd0);
    push_obj(REQ_QUERY, 1'b0, 16'd520, 16'd690, 16'd40, 16'd33);
    settle();

    // Every candidate equal: all edges pass the gate. The receiver holds off
    // meanwhile while queries keep coming, so the block backs up.
    write_reg(REG_MAXE, 10'd4);
    write_reg(REG_RATIO, 10'd1023);
    hold_asks++;
    for (int i = 0; i < 8; i++)
      push_obj(REQ_LOAD, i == 0, 16'd9000, 16'd9000, 16'd50, 16'd0);
    for (int q = 0; q < 4; q++)
      push_obj(REQ_QUERY, 1'b0, 16'd9000, 16'(9010 + q), 16'd50, 16'(q + 1));
    settle();

    // Random frames under a series of register settings, extremes included.
    budget = 54;
    for (int ph = 0; ph < 8 && budget > 0; ph++) begin
      case (ph)
        0: begin write_reg(REG_ALPHA, 10'd0); write_reg(REG_RATIO, 10'd256);
                 write_reg(REG_MAXE, 10'd1); end
        1: begin write_reg(REG_ALPHA, 10'd256); write_reg(REG_RATIO, 10'd1023);
                 write_reg(REG_MAXE, 10'd4); end
        2: begin write_reg(REG_ALPHA, 10'h3FF); write_reg(REG_MAXE, 10'd0); end
        3: begin write_reg(REG_RATIO, 10'd100); write_reg(REG_MAXE, 10'h3FF); end
        4: begin write_reg(REG_ALPHA, 10'd128); write_reg(REG_RATIO, 10'd307);
                 write_reg(REG_MAXE, 10'd2); end
        default: begin
          write_reg(REG_ALPHA, 10'($urandom_range(0, 300)));
          write_reg(REG_RATIO, 10'($urandom_range(256, 1023)));
          write_reg(REG_MAXE, 10'($urandom_range(1, 4)));
        end
      endcase
      for (int f = 0; f < 2 && budget > 0; f++) begin
        if (budget < 15) quiet = 1;
        rand_frame(budget);
        if (f == 1) settle();     // sender pause until the block drains
      end
      settle();
    end

    quiet = 1;
    settle();
    repeat (200) @(posedge clk);
    if (edges_due.size() != 0) begin
      $error("%0d expected results never arrived", edges_due.size());
      errors++;
    end
    $display("Run covered %0d input transfers (%0d queries), %0d results, %0d reg writes",
             n_in, n_queries, n_out, n_cfg);
    if (errors == 0) begin
      $display("PASS track_association_gate_core");
    end else begin
      $display("FAIL track_association_gate_core");
    end
    $finish;
  end
endmodule
